FILE: sv/vsph_pkg.sv
// ----------------------------------------------------------------------------
// vsph_pkg
// Shared types and constants for the velocity source priority hold block.
// ----------------------------------------------------------------------------
package vsph_pkg;

   localparam int CordicSteps = 16;
   localparam int DirLimit    = 11520;
   localparam logic [6:0] GainFresh = 7'd100;
   localparam logic [7:0] HoldReset = 8'd100;

   // One classified item passed from the front part to the back part.
   typedef struct packed {
      logic        in_range;
      logic        fresh;
      logic [2:0]  source;
      logic signed [16:0] x_speed;
      logic signed [16:0] y_speed;
      logic signed [15:0] turn_rate;
      logic        tick_end;
      logic        zero_vec;
      logic signed [8:0]  offset;
   } work_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SQRT,
      ST_DONE
   } back_state_type;

   function automatic logic signed [31:0] atan_entry(input logic [3:0] i);
      logic signed [31:0] r;
      begin
         case (i)
            4'd0:  r = 32'sd2949120;
            4'd1:  r = 32'sd1740967;
            4'd2:  r = 32'sd919879;
            4'd3:  r = 32'sd466945;
            4'd4:  r = 32'sd234379;
            4'd5:  r = 32'sd117304;
            4'd6:  r = 32'sd58666;
            4'd7:  r = 32'sd29335;
            4'd8:  r = 32'sd14668;
            4'd9:  r = 32'sd7334;
            4'd10: r = 32'sd3667;
            4'd11: r = 32'sd1833;
            4'd12: r = 32'sd917;
            4'd13: r = 32'sd458;
            4'd14: r = 32'sd229;
            default: r = 32'sd115;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: sv/vsph_front.sv
// ----------------------------------------------------------------------------
// vsph_front
// Accepts items, classifies them and places them in a two-entry queue.
// ----------------------------------------------------------------------------
module vsph_front
   import vsph_pkg::*;
#(
   parameter int SOURCES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  source_index,
   input  logic        new_command,
   input  logic signed [15:0] x_speed,
   input  logic signed [15:0] y_speed,
   input  logic signed [15:0] turn_rate,
   input  logic        tick_end,
   output logic        work_valid,
   input  logic        work_take,
   output work_type    work_item
);

   work_type   q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   work_type   cls;
   logic       do_push, do_pop;

   always_comb begin
      cls.in_range  = (int'(source_index) < SOURCES);
      cls.fresh     = new_command;
      cls.source    = {1'b0, source_index};
      cls.tick_end  = tick_end;
      cls.zero_vec  = (x_speed == 16'sd0) && (y_speed == 16'sd0);
      cls.turn_rate = turn_rate;
      if (x_speed < 0) begin
         cls.x_speed = -(17'(x_speed));
         cls.y_speed = -(17'(y_speed));
         cls.offset  = (y_speed >= 0) ? 9'sd180 : -9'sd180;
      end else begin
         cls.x_speed = 17'(x_speed);
         cls.y_speed = 17'(y_speed);
         cls.offset  = 9'sd0;
      end
   end

   // Negated operands carry 17 bits so that the most negative input negates cleanly.
   assign full       = cnt_ff[1];
   assign do_push    = push && !full;
   assign work_valid = (cnt_ff != 2'd0);
   assign do_pop     = work_valid && work_take;
   assign work_item  = q_ff[rd_ff];
   assign wr_in      = do_push ? !wr_ff : wr_ff;
   assign rd_in      = do_pop ? !rd_ff : rd_ff;
   assign cnt_in     = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

FILE: sv/vsph_back.sv
// ----------------------------------------------------------------------------
// vsph_back
// Converts fresh commands to polar form, updates per-source state and
// performs the tick-end priority selection into the output register.
// ----------------------------------------------------------------------------
module vsph_back
   import vsph_pkg::*;
#(
   parameter int SOURCES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  hold_ticks,
   input  logic        work_valid,
   output logic        work_take,
   input  work_type    work_item,
   output logic        busy,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] source_timeouts,
   output logic        selection_done,
   output logic        any_active,
   output logic [1:0]  active_source,
   output logic signed [14:0] out_direction,
   output logic [15:0] out_linear,
   output logic signed [15:0] out_angular,
   output logic [6:0]  out_gain
);

   back_state_type st_ff, st_in;
   work_type  it_ff;
   logic [3:0] step_ff, step_in;

   // CORDIC registers; inputs are scaled by 2^14, growth stays under 36 bits.
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] z_ff, z_in;

   // Bit-pair square root over a 32-bit radicand.
   logic [31:0] rem_ff, rem_in, root_ff, root_in;
   logic [32:0] bit_ff, bit_in;

   logic signed [14:0] dir_ff   [SOURCES];
   logic [15:0]        lin_ff   [SOURCES];
   logic signed [15:0] ang_ff   [SOURCES];
   logic [6:0]         gain_ff  [SOURCES];
   logic [7:0]         cnt_ff   [SOURCES];
   logic [31:0]        tmo_ff   [SOURCES];

   logic [31:0] r_tmo_ff;
   logic        r_sel_ff, r_any_ff, r_valid_ff;
   logic [1:0]  h_src_ff;
   logic signed [14:0] h_dir_ff;
   logic [15:0] h_lin_ff;
   logic signed [15:0] h_ang_ff;
   logic [6:0]  h_gain_ff;

   logic signed [35:0] shx, shy;
   logic signed [31:0] ts;
   logic signed [31:0] dsum;
   logic signed [21:0] dq;
   logic signed [14:0] dir_val;
   logic [32:0] trial;
   logic [31:0] root_fin;
   logic [2:0]  sidx;
   logic        commit;
   logic signed [16:0] rx, ry;
   logic [31:0] sqx, sqy;

   assign work_take = (st_ff == ST_IDLE) && work_valid && !r_valid_ff;
   assign busy      = (st_ff != ST_IDLE) || work_valid || r_valid_ff;
   assign empty     = !r_valid_ff;
   assign sidx      = it_ff.source;

   // Magnitude operands: the front part may have negated, squares are equal.
   assign rx  = it_ff.x_speed;
   assign ry  = it_ff.y_speed;

   always_comb begin
      shx   = cx_ff >>> step_ff;
      shy   = cy_ff >>> step_ff;
      ts    = atan_entry(step_ff);
      trial = {1'b0, root_ff} + bit_ff;
      sqx   = 32'(rx * rx);
      sqy   = 32'(ry * ry);
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (work_take) st_in = ST_CONV;
         ST_CONV: begin
            if (!it_ff.in_range || !it_ff.fresh) begin
               st_in = ST_DONE;
            end else if (step_ff == 4'(CordicSteps - 1)) begin
               st_in = ST_SQRT;
            end
         end
         ST_SQRT: if (bit_ff == 33'd0) st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      step_in = step_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      case (st_ff)
         ST_IDLE: begin
            step_in = 4'd0;
            cx_in   = 36'(work_item.x_speed) <<< 14;
            cy_in   = 36'(work_item.y_speed) <<< 14;
            z_in    = 32'sd0;
         end
         ST_CONV: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + shy;
               cy_in = cy_ff - shx;
               z_in  = z_ff + ts;
            end else begin
               cx_in = cx_ff - shy;
               cy_in = cy_ff + shx;
               z_in  = z_ff - ts;
            end
            step_in = step_ff + 4'd1;
            rem_in  = sqx + sqy;
            root_in = 32'd0;
            bit_in  = 33'h1_0000_0000;
         end
         ST_SQRT: begin
            // Once the bit has run out the root and remainder are final.
            if (bit_ff == 33'd0) begin
               bit_in = bit_ff;
            end else if (bit_ff > {1'b0, rem_ff} && root_ff == 32'd0) begin
               bit_in = bit_ff >> 2;
            end else if ({1'b0, rem_ff} >= trial) begin
               rem_in  = rem_ff - trial[31:0];
               root_in = (root_ff >> 1) + bit_ff[31:0];
               bit_in  = bit_ff >> 2;
            end else begin
               root_in = root_ff >> 1;
               bit_in  = bit_ff >> 2;
            end
         end
         default: ;
      endcase
   end

   // Final rounding of the root and the direction.
   always_comb begin
      root_fin = (rem_ff > root_ff) ? root_ff + 32'd1 : root_ff;
      dsum     = 32'(it_ff.offset) * 32'sd65536 + z_ff + 32'sd512;
      dq       = 22'(dsum >>> 10);
      if (it_ff.zero_vec) begin
         dir_val = 15'sd0;
      end else if (dq > 22'sd11520) begin
         dir_val = 15'(DirLimit);
      end else if (dq < -22'sd11520) begin
         dir_val = -15'(DirLimit);
      end else begin
         dir_val = 15'(dq);
      end
   end

   assign commit = (st_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      step_ff <= step_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (work_take) begin
         it_ff <= work_item;
      end
   end

   // Per-source state and selection. Selection sees the updated countdown.
   always_ff @(posedge clock) begin
      logic [7:0] c;
      logic       found;
      if (reset) begin
         for (int i = 0; i < SOURCES; i++) begin
            dir_ff[i]  <= '0;
            lin_ff[i]  <= '0;
            ang_ff[i]  <= '0;
            gain_ff[i] <= '0;
            cnt_ff[i]  <= '0;
            tmo_ff[i]  <= '0;
         end
         h_src_ff   <= '0;
         h_dir_ff   <= '0;
         h_lin_ff   <= '0;
         h_ang_ff   <= '0;
         h_gain_ff  <= '0;
         r_valid_ff <= 1'b0;
         r_tmo_ff   <= '0;
         r_sel_ff   <= 1'b0;
         r_any_ff   <= 1'b0;
      end else begin
         if (r_valid_ff && pop) begin
            r_valid_ff <= 1'b0;
         end
         if (commit) begin
            found = 1'b0;
            r_tmo_ff <= 32'd0;
            for (int i = SOURCES - 1; i >= 0; i--) begin
               c = cnt_ff[i];
               if (it_ff.in_range && sidx == 3'(i)) begin
                  if (it_ff.fresh) begin
                     c = hold_ticks;
                  end
                  if (c != 8'd0) c = c - 8'd1;
                  cnt_ff[i] <= c;
               end
            end
            for (int i = 0; i < SOURCES; i++) begin
               if (it_ff.in_range && sidx == 3'(i)) begin
                  if (it_ff.fresh) begin
                     dir_ff[i]  <= dir_val;
                     lin_ff[i]  <= root_fin[15:0];
                     ang_ff[i]  <= it_ff.turn_rate;
                     gain_ff[i] <= GainFresh;
                     r_tmo_ff   <= tmo_ff[i];
                  end else begin
                     dir_ff[i]  <= '0;
                     lin_ff[i]  <= '0;
                     ang_ff[i]  <= '0;
                     gain_ff[i] <= '0;
                     if (tmo_ff[i] != 32'hFFFF_FFFF) begin
                        tmo_ff[i] <= tmo_ff[i] + 32'd1;
                        r_tmo_ff  <= tmo_ff[i] + 32'd1;
                     end else begin
                        r_tmo_ff  <= tmo_ff[i];
                     end
                  end
               end
            end
            if (it_ff.tick_end) begin
               for (int i = 0; i < SOURCES; i++) begin
                  c = cnt_ff[i];
                  if (it_ff.in_range && sidx == 3'(i)) begin
                     if (it_ff.fresh) c = hold_ticks;
                     if (c != 8'd0) c = c - 8'd1;
                  end
                  if (!found && c != 8'd0) begin
                     found = 1'b1;
                     h_src_ff <= 2'(i);
                     if (it_ff.in_range && sidx == 3'(i)) begin
                        h_dir_ff  <= it_ff.fresh ? dir_val : 15'sd0;
                        h_lin_ff  <= it_ff.fresh ? root_fin[15:0] : 16'd0;
                        h_ang_ff  <= it_ff.fresh ? it_ff.turn_rate : 16'sd0;
                        h_gain_ff <= it_ff.fresh ? GainFresh : 7'd0;
                     end else begin
                        h_dir_ff  <= dir_ff[i];
                        h_lin_ff  <= lin_ff[i];
                        h_ang_ff  <= ang_ff[i];
                        h_gain_ff <= gain_ff[i];
                     end
                  end
               end
            end
            r_sel_ff   <= it_ff.tick_end;
            r_any_ff   <= found;
            r_valid_ff <= 1'b1;
         end
      end
   end

   assign source_timeouts = r_tmo_ff;
   assign selection_done  = r_sel_ff;
   assign any_active      = r_any_ff;
   assign active_source   = h_src_ff;
   assign out_direction   = h_dir_ff;
   assign out_linear      = h_lin_ff;
   assign out_angular     = h_ang_ff;
   assign out_gain        = h_gain_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      work_take |=> (st_ff == ST_CONV)) else $error("take did not start work");
   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      commit |=> !commit) else $error("double commit");
   a_result_after_commit: assert property (@(posedge clock) disable iff (reset)
      commit |=> r_valid_ff) else $error("result not posted");

endmodule

FILE: sv/velocity_source_priority_hold.sv
// ----------------------------------------------------------------------------
// velocity_source_priority_hold
// Per-source velocity hold with polar conversion and priority selection.
// ----------------------------------------------------------------------------
// A fresh command runs 16 CORDIC iterations, then a bit-pair square root of 17
// steps and a closing state. An item without a fresh command leaves the conversion
// state straight for the closing state. The back part takes the next item only
// once the result has been popped; the two-entry queue keeps taking pushes
// meanwhile until it is full.
// Reset is synchronous, clears all per-source state and held outputs, sets hold_ticks to 100.
// ----------------------------------------------------------------------------
module velocity_source_priority_hold
   import vsph_pkg::*;
#(
   parameter int SOURCES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_source_index,
   input  logic        req_new_command,
   input  logic signed [15:0] req_x_speed,
   input  logic signed [15:0] req_y_speed,
   input  logic signed [15:0] req_turn_rate,
   input  logic        req_tick_end,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_source_timeouts,
   output logic        rsp_selection_done,
   output logic        rsp_any_active,
   output logic [1:0]  rsp_active_source,
   output logic signed [14:0] rsp_out_direction,
   output logic [15:0] rsp_out_linear,
   output logic signed [15:0] rsp_out_angular,
   output logic [6:0]  rsp_out_gain,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_hold_ticks
);

   logic [7:0] hold_ff;
   logic       work_valid, work_take, busy;
   work_type   work_item;

   // Configuration is taken at any time; the user writes only while idle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HoldReset;
      end else if (csr_valid && csr_ready) begin
         hold_ff <= csr_hold_ticks;
      end
   end

   // The front part classifies each item and queues it for the back part.
   vsph_front #(.SOURCES(SOURCES)) u_front (
      .clock, .reset, .push, .full,
      .source_index (req_source_index),
      .new_command  (req_new_command),
      .x_speed      (req_x_speed),
      .y_speed      (req_y_speed),
      .turn_rate    (req_turn_rate),
      .tick_end     (req_tick_end),
      .work_valid, .work_take, .work_item
   );

   // The back part converts, updates state and holds the result item.
   vsph_back #(.SOURCES(SOURCES)) u_back (
      .clock, .reset,
      .hold_ticks (hold_ff),
      .work_valid, .work_take, .work_item, .busy,
      .empty, .pop,
      .source_timeouts (rsp_source_timeouts),
      .selection_done  (rsp_selection_done),
      .any_active      (rsp_any_active),
      .active_source   (rsp_active_source),
      .out_direction   (rsp_out_direction),
      .out_linear      (rsp_out_linear),
      .out_angular     (rsp_out_angular),
      .out_gain        (rsp_out_gain)
   );

   a_any_needs_sel: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_any_active |-> rsp_selection_done)
      else $error("active flag without selection");
   a_gain_values: assert property (@(posedge clock) disable iff (reset)
      rsp_out_gain == 7'd0 || rsp_out_gain == GainFresh) else $error("bad gain");
   a_busy_when_result: assert property (@(posedge clock) disable iff (reset)
      !empty |-> busy) else $error("result without busy");

endmodule

FILE: tb/tb_velocity_source_priority_hold.sv
// ----------------------------------------------------------------------------
// tb_velocity_source_priority_hold
// Self-checking bench for the velocity source priority hold block.
// ----------------------------------------------------------------------------
// A scoreboard object mirrors the per-source state, converts each fresh
// command to polar form on its own (CORDIC angle and rounded square root),
// and keeps a queue of expected results. Plain tasks push items and write the
// hold register. A separate process pops results with random stalls and
// compares them field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_velocity_source_priority_hold
   import vsph_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumSources = 4;
   localparam int WatchLimit = 20000;

   typedef struct packed {
      logic [1:0]         source;
      logic               fresh;
      logic signed [15:0] x_speed;
      logic signed [15:0] y_speed;
      logic signed [15:0] turn_rate;
      logic               tick_end;
   } velocity_item_type;

   typedef struct packed {
      logic [31:0]        timeouts;
      logic               selection_done;
      logic               any_active;
      logic [1:0]         active_source;
      logic signed [14:0] direction;
      logic [15:0]        linear;
      logic signed [15:0] angular;
      logic [6:0]         gain;
   } velocity_result_type;

   // Scoreboard: tracks the block's state and the results still owed by it.
   class velocity_scoreboard;
      logic [7:0]  hold_ticks;
      int          dir_q[NumSources];
      int          lin_q[NumSources];
      int          ang_q[NumSources];
      int          gain_q[NumSources];
      int          countdown[NumSources];
      logic [31:0] timeouts[NumSources];
      int          held_dir, held_lin, held_ang, held_gain, held_src;
      velocity_result_type pending_results[$];
      int          errors, checked, fresh_seen, selections;
      longint      atan_deg[16];

      function new();
         atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
         hold_ticks = HoldReset;
         for (int i = 0; i < NumSources; i++) begin
            dir_q[i] = 0; lin_q[i] = 0; ang_q[i] = 0; gain_q[i] = 0;
            countdown[i] = 0; timeouts[i] = 0;
         end
         held_dir = 0; held_lin = 0; held_ang = 0; held_gain = 0; held_src = 0;
         errors = 0; checked = 0; fresh_seen = 0; selections = 0;
      endfunction

      // Direction in Q9.6 degrees from a vectoring CORDIC on the command.
      function int polar_angle(int x, int y);
         longint cx, cy, nx, ny, z, off, d;
         z = 0;
         off = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            off = (y >= 0) ? 180 : -180;
            x = -x;
            y = -y;
         end
         cx = longint'(x) * 16384;
         cy = longint'(y) * 16384;
         for (int i = 0; i < 16; i++) begin
            if (cy > 0) begin
               nx = cx + (cy >>> i);
               ny = cy - (cx >>> i);
               z += atan_deg[i];
            end else begin
               nx = cx - (cy >>> i);
               ny = cy + (cx >>> i);
               z -= atan_deg[i];
            end
            cx = nx;
            cy = ny;
         end
         d = (off * 65536 + z + 512) >>> 10;
         if (d > DirLimit) d = DirLimit;
         if (d < -DirLimit) d = -DirLimit;
         return int'(d);
      endfunction

      // Magnitude rounded to the nearest integer.
      function int polar_magnitude(int x, int y);
         longint s, r, t;
         s = longint'(x) * x + longint'(y) * y;
         r = 0;
         for (int b = 17; b >= 0; b--) begin
            t = r + (longint'(1) << b);
            if (t * t <= s) r = t;
         end
         if (s - r * r > r) r++;
         return int'(r);
      endfunction

      function string fmt_result(velocity_result_type r);
         return $sformatf("to=%0d sel=%0b any=%0b src=%0d dir=%0d lin=%0d ang=%0d gain=%0d",
                          r.timeouts, r.selection_done, r.any_active, r.active_source,
                          r.direction, r.linear, r.angular, r.gain);
      endfunction

      function void note_item(velocity_item_type it);
         int s;
         velocity_result_type r;
         s = it.source;
         if (it.fresh) begin
            dir_q[s] = polar_angle(it.x_speed, it.y_speed);
            lin_q[s] = polar_magnitude(it.x_speed, it.y_speed);
            ang_q[s] = it.turn_rate;
            gain_q[s] = GainFresh;
            countdown[s] = hold_ticks;
            fresh_seen++;
         end else begin
            dir_q[s] = 0; lin_q[s] = 0; ang_q[s] = 0; gain_q[s] = 0;
            if (timeouts[s] != 32'hFFFF_FFFF) timeouts[s]++;
         end
         if (countdown[s] != 0) countdown[s]--;
         r.any_active = 1'b0;
         if (it.tick_end) begin
            selections++;
            for (int i = 0; i < NumSources; i++) begin
               if (countdown[i] != 0 && !r.any_active) begin
                  held_dir = dir_q[i]; held_lin = lin_q[i];
                  held_ang = ang_q[i]; held_gain = gain_q[i];
                  held_src = i;
                  r.any_active = 1'b1;
               end
            end
         end
         r.timeouts = timeouts[s];
         r.selection_done = it.tick_end;
         r.active_source = held_src[1:0];
         r.direction = held_dir[14:0];
         r.linear = held_lin[15:0];
         r.angular = held_ang[15:0];
         r.gain = held_gain[6:0];
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void check_result(velocity_result_type a);
         velocity_result_type e;
         checked++;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected (timeouts %0d)", $time,
                     a.timeouts);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (a !== e) begin
            errors++;
            $display("%0t: expected %s", $time, fmt_result(e));
            $display("%0t: actual   %s", $time, fmt_result(a));
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [1:0]         req_source_index = '0;
   logic               req_new_command = 1'b0;
   logic signed [15:0] req_x_speed = '0;
   logic signed [15:0] req_y_speed = '0;
   logic signed [15:0] req_turn_rate = '0;
   logic               req_tick_end = 1'b0;
   logic               empty;
   logic               pop = 1'b0;
   logic [31:0]        rsp_source_timeouts;
   logic               rsp_selection_done;
   logic               rsp_any_active;
   logic [1:0]         rsp_active_source;
   logic signed [14:0] rsp_out_direction;
   logic [15:0]        rsp_out_linear;
   logic signed [15:0] rsp_out_angular;
   logic [6:0]         rsp_out_gain;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_hold_ticks = '0;

   velocity_scoreboard hold_board = new();

   // When set, neither side inserts idle cycles.
   bit     steady_flow = 1'b0;
   // Number of cycles the receiver still holds off in one long stall.
   int     receiver_hold = 0;
   int     idle_count = 0;
   int     items_sent = 0;

   velocity_source_priority_hold u_top (
      .clock, .reset, .push, .full,
      .req_source_index, .req_new_command, .req_x_speed, .req_y_speed,
      .req_turn_rate, .req_tick_end,
      .empty, .pop,
      .rsp_source_timeouts, .rsp_selection_done, .rsp_any_active,
      .rsp_active_source, .rsp_out_direction, .rsp_out_linear,
      .rsp_out_angular, .rsp_out_gain,
      .csr_valid, .csr_ready, .csr_hold_ticks
   );

   always #5 clock = ~clock;

   // Result side: sample on the edge, then choose pop for the next cycle.
   always @(posedge clock) begin
      velocity_result_type got;
      if (!reset && pop && !empty) begin
         got.timeouts = rsp_source_timeouts;
         got.selection_done = rsp_selection_done;
         got.any_active = rsp_any_active;
         got.active_source = rsp_active_source;
         got.direction = rsp_out_direction;
         got.linear = rsp_out_linear;
         got.angular = rsp_out_angular;
         got.gain = rsp_out_gain;
         hold_board.check_result(got);
      end
      if (receiver_hold > 0) begin
         receiver_hold <= receiver_hold - 1;
         pop <= 1'b0;
      end else begin
         pop <= steady_flow || ($urandom_range(0, 99) >= 32);
      end
   end

   // Watchdog: any cycle with no handshake at all counts toward the limit.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready) || reset) begin
         idle_count <= 0;
      end else if (idle_count >= WatchLimit) begin
         $display("velocity_source_priority_hold: mismatch");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   function automatic logic signed [15:0] pick_speed();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sd0;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         1, 2: return 16'($signed($urandom_range(0, 8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   // Push stays high after an accepted item; callers that wait drop it first.
   task automatic send_item(velocity_item_type it);
      while (!steady_flow && $urandom_range(0, 99) < 32) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_source_index <= it.source;
      req_new_command <= it.fresh;
      req_x_speed <= it.x_speed;
      req_y_speed <= it.y_speed;
      req_turn_rate <= it.turn_rate;
      req_tick_end <= it.tick_end;
      do @(posedge clock); while (full);
      hold_board.note_item(it);
      items_sent++;
   endtask

   task automatic send(int s, int f, int x, int y, int t, int te);
      velocity_item_type it;
      it.source = 2'(s); it.fresh = 1'(f);
      it.x_speed = 16'(x); it.y_speed = 16'(y); it.turn_rate = 16'(t);
      it.tick_end = 1'(te);
      send_item(it);
   endtask

   // Mostly whole ticks: a rising run of sources closed by a tick end,
   // with some loose items in random order mixed in.
   task automatic send_random(int count);
      int sent;
      int first;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 3) == 0) begin
            send($urandom_range(0, 3), $urandom_range(0, 99) < 60, pick_speed(),
                 pick_speed(), pick_speed(), $urandom_range(0, 1));
            sent++;
         end else begin
            first = $urandom_range(0, 3);
            for (int s = first; s < NumSources && sent < count; s++) begin
               send(s, $urandom_range(0, 99) < 70, pick_speed(), pick_speed(),
                    pick_speed(), s == NumSources - 1);
               sent++;
            end
         end
      end
   endtask

   // The hold register is written only with the block drained and quiet.
   task automatic write_hold(logic [7:0] value);
      push <= 1'b0;
      while (hold_board.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_hold_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      hold_board.hold_ticks = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int settle;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero vector, axes, each quadrant, extreme values, timeouts.
      send(0, 1, 0, 0, 0, 1);
      send(0, 1, 4096, 0, 4096, 1);
      send(1, 1, 0, 4096, -4096, 0);
      send(2, 1, 0, -4096, 0, 0);
      send(3, 1, -4096, 0, 0, 1);
      send(0, 1, -4096, 1, 1, 1);
      send(0, 1, -4096, -1, -1, 1);
      send(0, 1, -32768, -32768, -32768, 1);
      send(0, 1, 32767, 32767, 32767, 1);
      send(0, 1, -32768, 32767, 0, 1);
      send(0, 1, 32767, -32768, 0, 1);
      send(0, 1, -32768, 0, 0, 0);
      send(1, 1, 3, -4, 7, 0);
      send(0, 0, 0, 0, 0, 1);
      send(1, 0, -1, -1, -1, 0);
      send(2, 0, 1, 1, 1, 0);
      send(3, 0, 0, 0, 0, 1);
      send(3, 0, 16'sh5555, 16'shAAAA, 16'sh5555, 1);
      send(2, 1, 16'shAAAA, 16'sh5555, 16'shAAAA, 1);

      // Hold of one and of zero: the reloaded countdown expires at once.
      write_hold(8'd1);
      send(0, 1, 1000, 2000, 300, 1);
      send(1, 1, -1000, 2000, 300, 1);
      send_random(40);
      write_hold(8'd0);
      send(0, 1, 1000, -2000, 300, 1);
      send_random(40);

      // Longest hold, with one long receiver stall that backs up the input.
      write_hold(8'd255);
      receiver_hold = 400;
      send_random(300);

      // A stretch with no idling on either side.
      write_hold(8'd2);
      steady_flow = 1'b1;
      send_random(250);
      steady_flow = 1'b0;

      for (int p = 0; p < 4; p++) begin
         write_hold(8'($urandom_range(1, 255)));
         send_random(280);
      end

      push <= 1'b0;
      while (hold_board.pending_results.size() != 0) @(posedge clock);
      settle = 0;
      while (settle < 60) begin
         @(posedge clock);
         settle++;
      end

      $display("Sent %0d items (%0d fresh commands, %0d tick-end selections), checked %0d results.",
               items_sent, hold_board.fresh_seen, hold_board.selections,
               hold_board.checked);
      $display("Hold values covered 0, 1, 2, 100, 255 and random settings.");
      if (hold_board.errors == 0 && hold_board.pending_results.size() == 0) begin
         $display("velocity_source_priority_hold: match");
      end else begin
         $display("velocity_source_priority_hold: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/vsph_pkg.sv
sv/vsph_front.sv
sv/vsph_back.sv
sv/velocity_source_priority_hold.sv
tb/tb_velocity_source_priority_hold.sv
